// ===== src/bfa_pkg.sv =====
// bfa_pkg: shared constants, types and helpers of the bitmap frame allocator
// used by bfa_csr, bfa_bitmap_mem and bitmap_frame_allocator
`default_nettype none

package bfa_pkg;

   localparam int MAX_FRAMES = 4096;
   localparam int WORD_BITS  = 32;
   localparam int NUM_WORDS  = MAX_FRAMES / WORD_BITS;
   localparam int WORD_IDX_W = $clog2(NUM_WORDS);
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);
   localparam int FRAME_W    = 12;
   localparam int COUNT_W    = 13;
   localparam int DESC_W     = 24;
   localparam int PAGE_SHIFT = 12;
   localparam int SEARCH_W   = COUNT_W - BIT_IDX_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT   = '0;
   localparam logic [COUNT_W-1:0]   FRAME_COUNT_RESET = COUNT_W'(4096);

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;
   localparam logic [1:0] OP_MARK  = 2'd3;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [1:0] STATUS_NOTHING = 2'd2;

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [WORD_IDX_W-1:0] widx_type;
   typedef logic [BIT_IDX_W-1:0]  bidx_type;
   typedef logic [FRAME_W-1:0]    frame_type;

   typedef struct packed {
      logic     en;
      widx_type addr;
   } mem_rd_type;

   typedef struct packed {
      logic     en;
      widx_type addr;
      word_type data;
   } mem_wr_type;

   // index of the lowest clear bit; isolate it as a one-hot, then encode
   function automatic bidx_type lowest_zero(word_type w);
      word_type inv;
      word_type one;
      bidx_type idx;
      inv = ~w;
      one = inv & (~inv + word_type'(1));
      idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (one[i]) begin
            idx = idx | bidx_type'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== src/bfa_csr.sv =====
// bfa_csr: register port holding frame_count
// depends on bfa_pkg
`default_nettype none

module bfa_csr
   import bfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [COUNT_W-1:0]    frame_count
);

   logic [COUNT_W-1:0]   frame_count_ff;
   logic [COUNT_W-1:0]   frame_count_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_hit;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign pready  = 1'b1;
   assign wr_hit  = psel & penable & pwrite & (reg_idx == REG_FRAME_COUNT);

   always_comb begin
      frame_count_in = frame_count_ff;
      if (wr_hit) begin
         frame_count_in = pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_COUNT_RESET;
      end else begin
         frame_count_ff <= frame_count_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == REG_FRAME_COUNT) begin
         prdata = CSR_DATA_W'(frame_count_ff);
      end
   end

   assign frame_count = frame_count_ff;

endmodule

`default_nettype wire

// ===== src/bfa_bitmap_mem.sv =====
// bfa_bitmap_mem: bitmap word memory, one read and one write port, registered read
// a per-word valid bit makes never-written words read as all free; depends on bfa_pkg
`default_nettype none

module bfa_bitmap_mem
   import bfa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire mem_rd_type rd,
   input  wire mem_wr_type wr,
   output word_type        rd_data
);

   word_type mem [NUM_WORDS];
   logic     valid_ff [NUM_WORDS];
   word_type rd_data_ff;
   logic     rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd.en) begin
         rd_valid_ff <= valid_ff[rd.addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

   // the sequencer never reads a word in the cycle it writes it
   assert property (@(posedge clock) disable iff (reset)
      !(rd.en && wr.en && (rd.addr == wr.addr)))
      else $error("bitmap read and write collide on one word");

endmodule

`default_nettype wire

// ===== src/bitmap_frame_allocator.sv =====
// bitmap_frame_allocator: first-fit page frame allocator, top level and sequencer
// depends on bfa_pkg, bfa_csr, bfa_bitmap_mem
//
// Requests enter on req_* (opcode, frame_number, current_frame, user_mode,
// writable) and each gives one result on rsp_* (status, frame_out,
// descriptor_word, frame_used). A channel moves a request at a rising edge
// with valid high and stall low. frame_count is written through the APB port
// at byte address 0 by the user, only while idle; the block does not enforce it.
// One request is worked at a time. Check, free, mark and allocate for a
// descriptor that already holds a frame go through a look state, which takes
// the word read at acceptance and, for mark and a free of a nonzero frame,
// writes it back modified, then through an output state that loads the result.
// Allocate scans one bitmap word per cycle through the memory read port, over
// the whole words of frame_count (at most 128); with none it answers no-free
// without a scan. The next request is accepted once the block is idle again.
// The result sits in an output register, so the next request is accepted
// while rsp_valid waits under rsp_stall; its result is loaded once the
// previous one is taken.
// Reset clears all per-word valid bits, so every frame reads free at once;
// no clearing pass is needed.
`default_nettype none

module bitmap_frame_allocator
   import bfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [FRAME_W-1:0]    req_frame_number,
   input  wire logic [FRAME_W-1:0]    req_current_frame,
   input  wire logic                  req_user_mode,
   input  wire logic                  req_writable,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [1:0]            rsp_status,
   output logic      [FRAME_W-1:0]    rsp_frame_out,
   output logic      [DESC_W-1:0]     rsp_descriptor_word,
   output logic                       rsp_frame_used,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [COUNT_W-1:0]  frame_count;
   logic [SEARCH_W-1:0] count_words;
   logic [SEARCH_W-1:0] search_words;
   logic [SEARCH_W-1:0] scan_next;

   mem_rd_type mem_rd;
   mem_wr_type mem_wr;
   word_type   rd_data;

   logic [1:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;
   frame_type  frm_ff, frm_in;
   logic       nothing_ff, nothing_in;
   logic       user_ff, user_in;
   logic       wr_ff, wr_in;
   widx_type   scan_ff, scan_in;

   logic [1:0]        res_status_ff, res_status_in;
   frame_type         res_frame_ff, res_frame_in;
   logic [DESC_W-1:0] res_desc_ff, res_desc_in;
   logic              res_used_ff, res_used_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   frame_type         rsp_frame_ff, rsp_frame_in;
   logic [DESC_W-1:0] rsp_desc_ff, rsp_desc_in;
   logic              rsp_used_ff, rsp_used_in;

   logic      accept;
   logic      out_free;
   bidx_type  look_bit;
   word_type  look_mask;
   bidx_type  free_bit;
   frame_type found_frame;

   bfa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .frame_count (frame_count)
   );

   bfa_bitmap_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd      (mem_rd),
      .wr      (mem_wr),
      .rd_data (rd_data)
   );

   // whole words only, saturated to the bitmap size
   assign count_words  = frame_count[COUNT_W-1:BIT_IDX_W];
   assign search_words = (count_words > SEARCH_W'(NUM_WORDS)) ? SEARCH_W'(NUM_WORDS)
                                                             : count_words;
   assign scan_next    = SEARCH_W'(scan_ff) + SEARCH_W'(1);

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   assign look_bit    = frm_ff[BIT_IDX_W-1:0];
   assign look_mask   = word_type'(1) << look_bit;
   assign free_bit    = lowest_zero(rd_data);
   assign found_frame = {scan_ff, free_bit};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      frm_in        = frm_ff;
      nothing_in    = nothing_ff;
      user_in       = user_ff;
      wr_in         = wr_ff;
      scan_in       = scan_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      res_desc_in   = res_desc_ff;
      res_used_in   = res_used_ff;
      mem_rd        = '0;
      mem_wr        = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = req_opcode;
               user_in    = req_user_mode;
               wr_in      = req_writable;
               nothing_in = 1'b0;
               frm_in     = req_frame_number;
               scan_in    = '0;
               state_in   = S_LOOK;
               case (req_opcode)
                  OP_ALLOC: begin
                     frm_in = req_current_frame;
                     if (req_current_frame != '0) begin
                        nothing_in = 1'b1;
                     end else if (search_words == '0) begin
                        res_status_in = STATUS_NO_FREE;
                        res_frame_in  = '0;
                        res_desc_in   = '0;
                        res_used_in   = 1'b0;
                        state_in      = S_OUT;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_FREE: begin
                     frm_in = req_current_frame;
                     // freeing frame zero leaves the bitmap alone
                     if (req_current_frame == '0) begin
                        nothing_in = 1'b1;
                     end
                  end
                  default: begin
                     frm_in = req_frame_number;
                  end
               endcase
               mem_rd.en   = (state_in != S_OUT);
               mem_rd.addr = (state_in == S_SCAN) ? '0 : frm_in[FRAME_W-1:BIT_IDX_W];
            end
         end

         S_LOOK: begin
            res_frame_in  = frm_ff;
            res_desc_in   = '0;
            res_status_in = nothing_ff ? STATUS_NOTHING : STATUS_DONE;
            res_used_in   = rd_data[look_bit];
            mem_wr.addr   = frm_ff[FRAME_W-1:BIT_IDX_W];
            if ((op_ff == OP_FREE) && !nothing_ff) begin
               mem_wr.en   = 1'b1;
               mem_wr.data = rd_data & ~look_mask;
               res_used_in = 1'b0;
            end else if (op_ff == OP_MARK) begin
               mem_wr.en   = 1'b1;
               mem_wr.data = rd_data | look_mask;
               res_used_in = 1'b1;
            end
            state_in = S_OUT;
         end

         S_SCAN: begin
            if (rd_data != '1) begin
               mem_wr.en     = 1'b1;
               mem_wr.addr   = scan_ff;
               mem_wr.data   = rd_data | (word_type'(1) << free_bit);
               res_status_in = STATUS_DONE;
               res_frame_in  = found_frame;
               res_desc_in   = {found_frame, {(PAGE_SHIFT-3){1'b0}}, user_ff, wr_ff, 1'b1};
               res_used_in   = 1'b1;
               state_in      = S_OUT;
            end else if (scan_next == search_words) begin
               res_status_in = STATUS_NO_FREE;
               res_frame_in  = '0;
               res_desc_in   = '0;
               res_used_in   = 1'b0;
               state_in      = S_OUT;
            end else begin
               scan_in     = scan_next[WORD_IDX_W-1:0];
               mem_rd.en   = 1'b1;
               mem_rd.addr = scan_next[WORD_IDX_W-1:0];
            end
         end

         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_desc_in   = rsp_desc_ff;
      rsp_used_in   = rsp_used_ff;
      if ((state_ff == S_OUT) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_frame_in  = res_frame_ff;
         rsp_desc_in   = res_desc_ff;
         rsp_used_in   = res_used_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      frm_ff        <= frm_in;
      nothing_ff    <= nothing_in;
      user_ff       <= user_in;
      wr_ff         <= wr_in;
      scan_ff       <= scan_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      res_desc_ff   <= res_desc_in;
      res_used_ff   <= res_used_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_desc_ff   <= rsp_desc_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_frame_out       = rsp_frame_ff;
   assign rsp_descriptor_word = rsp_desc_ff;
   assign rsp_frame_used      = rsp_used_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (SEARCH_W'(scan_ff) < search_words))
      else $error("scan ran past the searched words");

   assert property (@(posedge clock) disable iff (reset)
      mem_wr.en |-> ((state_ff == S_LOOK) || (state_ff == S_SCAN)))
      else $error("bitmap written outside look or scan");

   assert property (@(posedge clock) disable iff (reset)
      (mem_wr.en && (state_ff == S_SCAN)) |->
         ($countones(mem_wr.data) == $countones(rd_data) + 1))
      else $error("allocation did not set exactly one free bit");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted request was dropped");

endmodule

`default_nettype wire
